/* hdl/nips_pkg.sv */
// ----------------------------------------------------------------------------
// nips_pkg: shared types and constants of the node id provisioning slave
// Holds the command record between front and back, field widths, frame codes
// and register indexes.
// ----------------------------------------------------------------------------
package nips_pkg;

   // default sizes of the assign reassembly buffer and of one segment's chunk
   localparam int DEF_ASSIGN_BYTES = 16;
   localparam int DEF_SEG_BYTES    = 5;

   // depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // field widths
   localparam int TIME_W  = 32;
   localparam int ID_W    = 11;
   localparam int DLC_W   = 4;
   localparam int DATA_W  = 64;
   localparam int UID_W   = 64;
   localparam int NODE_W  = 8;
   localparam int BASE_W  = 16;
   localparam int CSR_IDX_W = 3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_UID       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOARD_MODEL      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRMWARE_VERSION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPABILITY_BITS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_COUNT      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_COUNT     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STORED_NODE_ID   = 3'd6;

   // frame identifiers and operation codes
   localparam logic [ID_W-1:0] ID_MASTER   = 11'h7E5;
   localparam logic [7:0]      OP_DISCOVER = 8'h01;
   localparam logic [7:0]      OP_IDENTIFY = 8'h02;
   localparam logic [7:0]      OP_ASSIGN   = 8'h03;
   localparam logic [7:0]      OP_ACK      = 8'h04;

   // node id codes
   localparam logic [NODE_W-1:0] NODE_UNASSIGNED = 8'h7F;
   localparam logic [NODE_W-1:0] STORED_NONE     = 8'hFF;

   // frame length thresholds
   localparam logic [DLC_W-1:0] DLC_MIN_FRAME    = 4'd4;
   localparam logic [DLC_W-1:0] DLC_MIN_DISCOVER = 4'd5;
   localparam logic [DLC_W-1:0] DLC_MIN_ASSIGN   = 4'd8;

   // identify back-off mask and assign completion rules
   localparam logic [TIME_W-1:0] DELAY_MASK = 32'h0000_000F;
   localparam logic [7:0]        FINAL_LEN_LIMIT = 8'd6;
   localparam int                FINAL_MIN_BYTES = 13;

   // outgoing payload sizes and segmenting
   localparam int PAY_BYTES   = 20;
   localparam int ACK_BYTES   = 14;
   localparam int REM_W       = $clog2(PAY_BYTES + 1);
   localparam int CHUNK_W     = 3;
   localparam int MAX_RESULTS = 4;
   localparam int SEG_W       = $clog2(MAX_RESULTS);
   localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(MAX_RESULTS - 1);
   localparam logic [REM_W-1:0] IDENT_LEN = REM_W'(PAY_BYTES);
   localparam logic [REM_W-1:0] ACK_LEN   = REM_W'(ACK_BYTES);

   // classified request
   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_TICK,
      CMD_DISCOVER,
      CMD_ASSIGN
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [TIME_W-1:0]   now_ms;
      logic [DATA_W-1:0]   data;
   } cmd_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CHECK,
      BK_EMIT
   } back_state_type;

   // byte of an assign chunk at position rel; bytes past the frame read as zero
   function automatic logic [7:0] chunk_byte(input logic [DATA_W-1:0] data,
                                             input logic [8:0] rel);
      logic [7:0] b;
      case (rel)
         9'd0:    b = data[31:24];
         9'd1:    b = data[39:32];
         9'd2:    b = data[47:40];
         9'd3:    b = data[55:48];
         9'd4:    b = data[63:56];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

/* hdl/nips_ifs.sv */
// ----------------------------------------------------------------------------
// nips_ifs: channel interfaces of the node id provisioning slave
// Request, response and register write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface nips_req_if import nips_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [TIME_W-1:0] now_ms;
   logic [ID_W-1:0]   frame_id;
   logic [DLC_W-1:0]  frame_dlc;
   logic [DATA_W-1:0] frame_data;

   modport source (output valid, req_type, now_ms, frame_id, frame_dlc, frame_data,
                   input ready);
   modport sink   (input valid, req_type, now_ms, frame_id, frame_dlc, frame_data,
                   output ready);
endinterface

interface nips_rsp_if import nips_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              frame_valid;
   logic [DLC_W-1:0]  out_dlc;
   logic [DATA_W-1:0] out_data;
   logic              last;
   logic [NODE_W-1:0] current_node_id;
   logic              node_assigned;
   logic              save_request;
   logic [BASE_W-1:0] input_base_index;
   logic [BASE_W-1:0] output_base_index;

   modport source (output valid, frame_valid, out_dlc, out_data, last, current_node_id,
                   node_assigned, save_request, input_base_index, output_base_index,
                   input ready);
   modport sink   (input valid, frame_valid, out_dlc, out_data, last, current_node_id,
                   node_assigned, save_request, input_base_index, output_base_index,
                   output ready);
endinterface

interface nips_csr_if import nips_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/node_id_provisioning_slave_top.sv */
// ----------------------------------------------------------------------------
// node_id_provisioning_slave_top: node id provisioning slave
// Serves discover and assign exchanges on received CAN frames and sends
// segmented identify replies on millisecond ticks and acknowledges to assigns.
//
//   channel   | direction | carries
//   ----------+-----------+-------------------------------------------------
//   req_bus   | in        | received frame or millisecond tick
//   rsp_bus   | out       | one result per frame sent, or one status result
//   csr_bus   | in        | register index and write data, always ready
//
// A request that sends nothing is handled in idle; the next may follow in the
// next cycle if the response side is free. A final assign whose uid misses
// also passes the uid check. A fired identify sends four segments, a
// matching final assign three after the uid check, one per cycle at the
// response register unless it stalls. Reset clears node state and registers;
// no clearing pass. The two-entry queue takes requests in a stall until full.
// ----------------------------------------------------------------------------
module node_id_provisioning_slave_top import nips_pkg::*; #(
   parameter int ASSIGN_BUFFER_BYTES   = DEF_ASSIGN_BYTES,
   parameter int SEGMENT_PAYLOAD_BYTES = DEF_SEG_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   nips_req_if.sink    req_bus,
   nips_rsp_if.source  rsp_bus,
   nips_csr_if.sink    csr_bus
);

   logic    push, q_full, pop, q_valid;
   cmd_type push_cmd, q_cmd;

   // classify incoming requests
   nips_front u_front (
      .req_bus  (req_bus),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   // hold commands between decoder and engine
   nips_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd)
   );

   // carry out commands and send results
   nips_back #(
      .ASSIGN_BUFFER_BYTES   (ASSIGN_BUFFER_BYTES),
      .SEGMENT_PAYLOAD_BYTES (SEGMENT_PAYLOAD_BYTES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .pop     (pop),
      .csr_bus (csr_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

/* hdl/nips_front.sv */
// ----------------------------------------------------------------------------
// nips_front: request decoder
// Accepts requests and classifies them into tick, discover, assign or
// ignored commands for the back end.
// ----------------------------------------------------------------------------
module nips_front import nips_pkg::*; (
   nips_req_if.sink req_bus,
   input  logic     q_full,
   output logic     push,
   output cmd_type  push_cmd
);

   logic [7:0] op;
   logic       master_frame;

   // take a request whenever the queue has room
   assign req_bus.ready = !q_full;
   assign push          = req_bus.valid && !q_full;

   // classify: foreign or short frames and unknown ops carry no work
   assign op           = req_bus.frame_data[7:0];
   assign master_frame = (req_bus.frame_id == ID_MASTER) && (req_bus.frame_dlc >= DLC_MIN_FRAME);

   always_comb begin
      push_cmd.now_ms = req_bus.now_ms;
      push_cmd.data   = req_bus.frame_data;
      push_cmd.kind   = CMD_NONE;
      if (req_bus.req_type) begin
         push_cmd.kind = CMD_TICK;
      end else if (master_frame) begin
         if (op == OP_DISCOVER && req_bus.frame_dlc >= DLC_MIN_DISCOVER) begin
            push_cmd.kind = CMD_DISCOVER;
         end else if (op == OP_ASSIGN && req_bus.frame_dlc >= DLC_MIN_ASSIGN) begin
            push_cmd.kind = CMD_ASSIGN;
         end
      end
   end

endmodule

/* hdl/nips_queue.sv */
// ----------------------------------------------------------------------------
// nips_queue: command queue
// Short first-in first-out queue of classified requests between front and
// back end.
// ----------------------------------------------------------------------------
module nips_queue import nips_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    q_valid,
   output cmd_type q_cmd
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_cmd   = slot_ff[head_ff];
   assign do_pop  = pop && q_valid;

   // advance pointers with wrap at the depth
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("command queue written while full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("command queue count out of range");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("command queue lost a request");

endmodule

/* hdl/nips_back.sv */
// ----------------------------------------------------------------------------
// nips_back: provisioning engine and frame sender
// Holds the node state and registers, carries out queued commands, reassembles
// assign segments and sends identify and acknowledge payloads as segments.
// ----------------------------------------------------------------------------
module nips_back import nips_pkg::*; #(
   parameter int ASSIGN_BUFFER_BYTES   = DEF_ASSIGN_BYTES,
   parameter int SEGMENT_PAYLOAD_BYTES = DEF_SEG_BYTES
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  cmd_type  q_cmd,
   output logic     pop,
   nips_csr_if.sink csr_bus,
   nips_rsp_if.source rsp_bus
);

   localparam int OFF_W = $clog2(ASSIGN_BUFFER_BYTES + 1);
   localparam logic [8:0]       ASB_9    = 9'(ASSIGN_BUFFER_BYTES);
   localparam logic [REM_W-1:0] SEG_REM  = REM_W'(SEGMENT_PAYLOAD_BYTES);
   localparam logic [CHUNK_W-1:0] SEG_CHUNK = CHUNK_W'(SEGMENT_PAYLOAD_BYTES);
   localparam logic [OFF_W-1:0] FINAL_MIN = OFF_W'(FINAL_MIN_BYTES);

   // configuration registers
   logic [UID_W-1:0]  uid_ff;
   logic [15:0]       board_ff, firmware_ff, caps_ff;
   logic [7:0]        in_count_ff, out_count_ff;

   // node state
   back_state_type    state_ff, state_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic              assigned_ff, assigned_in;
   logic [TIME_W-1:0] nonce_ff, nonce_in;
   logic [TIME_W-1:0] deadline_ff, deadline_in;
   logic              pending_ff, pending_in;
   logic [OFF_W-1:0]  offset_ff, offset_in;
   logic [BASE_W-1:0] in_base_ff, in_base_in;
   logic [BASE_W-1:0] out_base_ff, out_base_in;
   logic [7:0]        asm_bytes_ff [ASSIGN_BUFFER_BYTES];
   logic [7:0]        asm_bytes_in [ASSIGN_BUFFER_BYTES];

   // segment sender
   logic [PAY_BYTES*8-1:0] pay_ff, pay_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [SEG_W-1:0]  seg_ff, seg_in;
   logic [7:0]        op_ff, op_in;
   logic              save_ff, save_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_frame_ff, rsp_frame_in;
   logic [DLC_W-1:0]  rsp_dlc_ff, rsp_dlc_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_save_ff, rsp_save_in;
   logic [NODE_W-1:0] rsp_node_ff;
   logic              rsp_assigned_ff;
   logic [BASE_W-1:0] rsp_in_base_ff, rsp_out_base_ff;

   // control
   logic              out_free;
   logic              tick_fire, assign_final, uid_match, seg_last;
   logic              emit_none, emit_seg, do_fire, do_discover, do_assign, do_take;
   logic              load_rsp;

   // assign decode
   logic [7:0]        a_seg, a_len;
   logic [OFF_W-1:0]  a_base, a_new_off;
   logic [8:0]        a_sum, a_rel;
   logic              a_fits;
   logic [UID_W-1:0]  asm_uid;

   // segment build
   logic [CHUNK_W-1:0] chunk;
   logic [DATA_W-1:0]  seg_word;

   assign csr_bus.ready = 1'b1;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // decode the command at the queue head
   assign tick_fire = (q_cmd.kind == CMD_TICK) && pending_ff && (q_cmd.now_ms >= deadline_ff);
   assign a_seg     = q_cmd.data[15:8];
   assign a_len     = q_cmd.data[23:16];
   assign a_base    = (a_seg == 8'd0) ? '0 : offset_ff;
   assign a_sum     = 9'(a_base) + {1'b0, a_len};
   assign a_fits    = (a_sum <= ASB_9);
   assign a_new_off = a_fits ? OFF_W'(a_sum) : a_base;
   assign assign_final = (q_cmd.kind == CMD_ASSIGN) && (a_len < FINAL_LEN_LIMIT) &&
                         (a_new_off >= FINAL_MIN);

   // match the reassembled uid
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         asm_uid[8*i +: 8] = asm_bytes_ff[i];
      end
   end
   assign uid_match = (asm_uid == uid_ff);

   // current segment: chunk, last flag and frame word
   assign chunk    = (rem_ff < SEG_REM) ? CHUNK_W'(rem_ff) : SEG_CHUNK;
   assign seg_last = (rem_ff <= SEG_REM) || (seg_ff == SEG_LAST);

   always_comb begin
      seg_word        = '0;
      seg_word[7:0]   = op_ff;
      seg_word[15:8]  = 8'(seg_ff);
      seg_word[23:16] = 8'(chunk);
      for (int i = 0; i < SEGMENT_PAYLOAD_BYTES; i++) begin
         if (CHUNK_W'(i) < chunk) begin
            seg_word[8*(3+i) +: 8] = pay_ff[8*i +: 8];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid && out_free) begin
               if (tick_fire) begin
                  state_in = BK_EMIT;
               end else if (assign_final) begin
                  state_in = BK_CHECK;
               end
            end
         end
         BK_CHECK: begin
            if (uid_match) begin
               state_in = BK_EMIT;
            end else if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         BK_EMIT: begin
            if (out_free && seg_last) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      pop         = 1'b0;
      emit_none   = 1'b0;
      emit_seg    = 1'b0;
      do_fire     = 1'b0;
      do_discover = 1'b0;
      do_assign   = 1'b0;
      do_take     = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid && out_free) begin
               pop         = 1'b1;
               do_fire     = tick_fire;
               do_discover = (q_cmd.kind == CMD_DISCOVER) && !assigned_ff;
               do_assign   = (q_cmd.kind == CMD_ASSIGN);
               emit_none   = !tick_fire && !assign_final;
            end
         end
         BK_CHECK: begin
            do_take   = uid_match;
            emit_none = !uid_match && out_free;
         end
         BK_EMIT: begin
            emit_seg = out_free;
         end
         default: ;
      endcase
   end

   // node state, reassembly and sender next values
   always_comb begin
      node_in     = node_ff;
      assigned_in = assigned_ff;
      nonce_in    = nonce_ff;
      deadline_in = deadline_ff;
      pending_in  = pending_ff;
      offset_in   = offset_ff;
      in_base_in  = in_base_ff;
      out_base_in = out_base_ff;
      pay_in      = pay_ff;
      rem_in      = rem_ff;
      seg_in      = seg_ff;
      op_in       = op_ff;
      save_in     = save_ff;
      a_rel       = '0;
      for (int j = 0; j < ASSIGN_BUFFER_BYTES; j++) begin
         asm_bytes_in[j] = asm_bytes_ff[j];
      end

      // discover: keep the nonce and schedule the identify reply
      if (do_discover) begin
         nonce_in    = q_cmd.data[39:8];
         deadline_in = q_cmd.now_ms + ((q_cmd.now_ms ^ uid_ff[TIME_W-1:0]) & DELAY_MASK);
         pending_in  = 1'b1;
      end

      // tick past the deadline: load the identify payload
      if (do_fire) begin
         pending_in = 1'b0;
         pay_in     = {out_count_ff, in_count_ff, caps_ff, firmware_ff, board_ff,
                       uid_ff, nonce_ff};
         rem_in     = IDENT_LEN;
         seg_in     = '0;
         op_in      = OP_IDENTIFY;
         save_in    = 1'b0;
      end

      // assign segment: store the chunk when it fits
      if (do_assign) begin
         offset_in = a_new_off;
         for (int j = 0; j < ASSIGN_BUFFER_BYTES; j++) begin
            a_rel = 9'(j) - 9'(a_base);
            if (a_fits && (9'(j) >= 9'(a_base)) && (9'(j) < a_sum)) begin
               asm_bytes_in[j] = chunk_byte(q_cmd.data, a_rel);
            end
         end
      end

      // matching final segment: take the new id and load the acknowledge
      if (do_take) begin
         node_in     = asm_bytes_ff[8];
         in_base_in  = {asm_bytes_ff[10], asm_bytes_ff[9]};
         out_base_in = {asm_bytes_ff[12], asm_bytes_ff[11]};
         assigned_in = 1'b1;
         save_in     = 1'b1;
         pay_in      = {{(PAY_BYTES - ACK_BYTES){8'h00}},
                        asm_bytes_ff[12], asm_bytes_ff[11], asm_bytes_ff[10], asm_bytes_ff[9],
                        8'h00, asm_bytes_ff[8], uid_ff};
         rem_in      = ACK_LEN;
         seg_in      = '0;
         op_in       = OP_ACK;
      end

      // advance the sender past the segment just shown
      if (emit_seg) begin
         pay_in = pay_ff >> (8 * SEGMENT_PAYLOAD_BYTES);
         rem_in = rem_ff - REM_W'(chunk);
         seg_in = seg_ff + 1'b1;
      end

      // register writes: the stored id reloads the node
      if (csr_bus.valid && (csr_bus.index == CSR_STORED_NODE_ID)) begin
         if (csr_bus.data[NODE_W-1:0] != STORED_NONE) begin
            node_in     = csr_bus.data[NODE_W-1:0];
            assigned_in = 1'b1;
         end else begin
            node_in     = NODE_UNASSIGNED;
            assigned_in = 1'b0;
         end
      end
   end

   // response register next values
   assign load_rsp = emit_none || emit_seg;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_frame_in = rsp_frame_ff;
      rsp_dlc_in   = rsp_dlc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_save_in  = rsp_save_ff;
      if (emit_none) begin
         rsp_valid_in = 1'b1;
         rsp_frame_in = 1'b0;
         rsp_dlc_in   = '0;
         rsp_data_in  = '0;
         rsp_last_in  = 1'b1;
         rsp_save_in  = 1'b0;
      end else if (emit_seg) begin
         rsp_valid_in = 1'b1;
         rsp_frame_in = 1'b1;
         rsp_dlc_in   = DLC_W'(3) + DLC_W'(chunk);
         rsp_data_in  = seg_word;
         rsp_last_in  = seg_last;
         rsp_save_in  = save_ff;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         node_ff      <= NODE_UNASSIGNED;
         assigned_ff  <= 1'b0;
         nonce_ff     <= '0;
         deadline_ff  <= '0;
         pending_ff   <= 1'b0;
         offset_ff    <= '0;
         in_base_ff   <= '0;
         out_base_ff  <= '0;
         seg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         uid_ff       <= '0;
         board_ff     <= '0;
         firmware_ff  <= '0;
         caps_ff      <= '0;
         in_count_ff  <= '0;
         out_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         assigned_ff  <= assigned_in;
         nonce_ff     <= nonce_in;
         deadline_ff  <= deadline_in;
         pending_ff   <= pending_in;
         offset_ff    <= offset_in;
         in_base_ff   <= in_base_in;
         out_base_ff  <= out_base_in;
         seg_ff       <= seg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            case (csr_bus.index)
               CSR_DEVICE_UID:       uid_ff       <= csr_bus.data;
               CSR_BOARD_MODEL:      board_ff     <= csr_bus.data[15:0];
               CSR_FIRMWARE_VERSION: firmware_ff  <= csr_bus.data[15:0];
               CSR_CAPABILITY_BITS:  caps_ff      <= csr_bus.data[15:0];
               CSR_INPUT_COUNT:      in_count_ff  <= csr_bus.data[7:0];
               CSR_OUTPUT_COUNT:     out_count_ff <= csr_bus.data[7:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int j = 0; j < ASSIGN_BUFFER_BYTES; j++) begin
         asm_bytes_ff[j] <= asm_bytes_in[j];
      end
      pay_ff      <= pay_in;
      rem_ff      <= rem_in;
      op_ff       <= op_in;
      save_ff     <= save_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_dlc_ff   <= rsp_dlc_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_save_ff  <= rsp_save_in;
      if (load_rsp) begin
         rsp_node_ff     <= node_ff;
         rsp_assigned_ff <= assigned_ff;
         rsp_in_base_ff  <= in_base_ff;
         rsp_out_base_ff <= out_base_ff;
      end
   end

   // drive the response channel
   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.frame_valid       = rsp_frame_ff;
   assign rsp_bus.out_dlc           = rsp_dlc_ff;
   assign rsp_bus.out_data          = rsp_data_ff;
   assign rsp_bus.last              = rsp_last_ff;
   assign rsp_bus.current_node_id   = rsp_node_ff;
   assign rsp_bus.node_assigned     = rsp_assigned_ff;
   assign rsp_bus.save_request      = rsp_save_ff;
   assign rsp_bus.input_base_index  = rsp_in_base_ff;
   assign rsp_bus.output_base_index = rsp_out_base_ff;

   a_offset_bound: assert property (@(posedge clock) disable iff (reset)
      offset_ff <= OFF_W'(ASSIGN_BUFFER_BYTES))
      else $error("reassembly offset beyond buffer");

   a_empty_result_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_frame_ff) |-> (rsp_data_ff == '0 && rsp_dlc_ff == '0 && rsp_last_ff))
      else $error("empty result carries frame bits");

   a_save_implies_assigned: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_save_ff) |-> rsp_assigned_ff)
      else $error("save request without assigned node");

   a_fire_clears_pending: assert property (@(posedge clock) disable iff (reset)
      do_fire |=> (!pending_ff && state_ff == BK_EMIT))
      else $error("identify fired but still pending");

   // the uid check follows the idle state, or holds while a miss waits on a stall
   a_check_after_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CHECK) |-> ($past(state_ff) != BK_EMIT))
      else $error("uid check entered out of order");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the node id provisioning slave
// Drives received frames and millisecond ticks, predicts every identify,
// acknowledge and status reply from a local copy of the node state, and
// compares each reply field by field. Directed discover, assign and ignored
// frame cases come first, then random phases under changing registers and
// handshake idling, and a long response hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb_top;
   import nips_pkg::*;

   localparam int CLK_PERIOD    = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_TARGET  = 25;
   localparam int HOLD_CYCLES   = 40;

   // request kinds
   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [TIME_W-1:0] now_ms;
      logic [ID_W-1:0]   frame_id;
      logic [DLC_W-1:0]  frame_dlc;
      logic [DATA_W-1:0] frame_data;
   } node_req_type;

   typedef struct {
      logic              frame_valid;
      logic [DLC_W-1:0]  out_dlc;
      logic [DATA_W-1:0] out_data;
      logic              last;
      logic [NODE_W-1:0] node_id;
      logic              assigned;
      logic              save;
      logic [BASE_W-1:0] in_base;
      logic [BASE_W-1:0] out_base;
   } node_reply_type;

   logic clock;
   logic reset;

   nips_req_if req_bus ();
   nips_rsp_if rsp_bus ();
   nips_csr_if csr_bus ();

   node_id_provisioning_slave_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // local copy of registers and node state
   logic [UID_W-1:0]  cfg_uid;
   logic [15:0]       cfg_board;
   logic [15:0]       cfg_firmware;
   logic [15:0]       cfg_caps;
   logic [7:0]        cfg_inputs;
   logic [7:0]        cfg_outputs;
   logic [NODE_W-1:0] node_id;
   logic              node_is_assigned;
   logic [31:0]       disc_nonce;
   logic [31:0]       ident_deadline;
   logic              ident_pending;
   logic [7:0]        assign_buf [0:DEF_ASSIGN_BYTES-1];
   int                assign_fill;
   logic [BASE_W-1:0] base_in;
   logic [BASE_W-1:0] base_out;

   node_reply_type expected_replies [$];

   int send_idle_pct;
   int rsp_idle_pct;
   int hold_request;
   int error_count;
   int requests_sent;
   int acted_requests;
   int registers_written;
   int replies_checked;
   int identify_frames;
   int ack_frames;

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         report_mismatch(name, got, want);
      end
   endtask

   function automatic node_reply_type with_status(input node_reply_type rep,
                                                  input logic save);
      node_reply_type r;
      r          = rep;
      r.node_id  = node_id;
      r.assigned = node_is_assigned;
      r.save     = save;
      r.in_base  = base_in;
      r.out_base = base_out;
      return r;
   endfunction

   // update node state for one request and queue the replies it causes
   task automatic predict_replies(input node_req_type r);
      logic [7:0]        pay [0:PAY_BYTES-1];
      logic [7:0]        fb [0:7];
      logic [7:0]        seg_len;
      logic [7:0]        reply_op;
      logic [31:0]       delay;
      logic [UID_W-1:0]  got_uid;
      logic [DATA_W-1:0] word;
      logic              save;
      node_reply_type    rep;
      int                pay_len;
      int                nseg;
      int                off;
      int                chunk;
      int                i;
      pay_len  = 0;
      save     = 1'b0;
      reply_op = 8'h00;
      for (i = 0; i < 8; i++) begin
         fb[i] = r.frame_data[8*i +: 8];
      end
      if (r.req_type == REQ_TICK) begin
         // fire the identify once the deadline has passed
         if (ident_pending && r.now_ms >= ident_deadline) begin
            acted_requests++;
            ident_pending = 1'b0;
            for (i = 0; i < 4; i++) begin
               pay[i] = disc_nonce[8*i +: 8];
            end
            for (i = 0; i < 8; i++) begin
               pay[4 + i] = cfg_uid[8*i +: 8];
            end
            pay[12]  = cfg_board[7:0];
            pay[13]  = cfg_board[15:8];
            pay[14]  = cfg_firmware[7:0];
            pay[15]  = cfg_firmware[15:8];
            pay[16]  = cfg_caps[7:0];
            pay[17]  = cfg_caps[15:8];
            pay[18]  = cfg_inputs;
            pay[19]  = cfg_outputs;
            pay_len  = PAY_BYTES;
            reply_op = OP_IDENTIFY;
         end
      end else if (r.frame_id == ID_MASTER && r.frame_dlc >= DLC_MIN_FRAME) begin
         if (fb[0] == OP_DISCOVER) begin
            if (!node_is_assigned && r.frame_dlc >= DLC_MIN_DISCOVER) begin
               acted_requests++;
               disc_nonce     = {fb[4], fb[3], fb[2], fb[1]};
               delay          = (r.now_ms ^ cfg_uid[31:0]) & DELAY_MASK;
               ident_deadline = r.now_ms + delay;
               ident_pending  = 1'b1;
            end
         end else if (fb[0] == OP_ASSIGN && r.frame_dlc >= DLC_MIN_ASSIGN) begin
            acted_requests++;
            seg_len = fb[2];
            if (fb[1] == 8'h00) begin
               assign_fill = 0;
            end
            // store the chunk unless it runs past the buffer
            if (assign_fill + seg_len <= DEF_ASSIGN_BYTES) begin
               for (i = 0; i < seg_len; i++) begin
                  if (i + 3 < 8) begin
                     assign_buf[assign_fill + i] = fb[i + 3];
                  end else begin
                     assign_buf[assign_fill + i] = 8'h00;
                  end
               end
               assign_fill += seg_len;
            end
            if (seg_len < FINAL_LEN_LIMIT && assign_fill >= FINAL_MIN_BYTES) begin
               for (i = 0; i < 8; i++) begin
                  got_uid[8*i +: 8] = assign_buf[i];
               end
               if (got_uid == cfg_uid) begin
                  node_id          = assign_buf[8];
                  base_in          = {assign_buf[10], assign_buf[9]};
                  base_out         = {assign_buf[12], assign_buf[11]};
                  node_is_assigned = 1'b1;
                  save             = 1'b1;
                  for (i = 0; i < 8; i++) begin
                     pay[i] = cfg_uid[8*i +: 8];
                  end
                  pay[8]   = node_id;
                  pay[9]   = 8'h00;
                  pay[10]  = base_in[7:0];
                  pay[11]  = base_in[15:8];
                  pay[12]  = base_out[7:0];
                  pay[13]  = base_out[15:8];
                  pay_len  = ACK_BYTES;
                  reply_op = OP_ACK;
               end
            end
         end
      end
      // cut the payload into segments, at most four of them
      nseg = 0;
      off  = 0;
      while (off < pay_len && nseg < MAX_RESULTS) begin
         chunk = pay_len - off;
         if (chunk > DEF_SEG_BYTES) begin
            chunk = DEF_SEG_BYTES;
         end
         word        = '0;
         word[7:0]   = reply_op;
         word[15:8]  = 8'(nseg);
         word[23:16] = 8'(chunk);
         for (i = 0; i < chunk; i++) begin
            word[8*(3 + i) +: 8] = pay[off + i];
         end
         rep.frame_valid = 1'b1;
         rep.out_dlc     = DLC_W'(3 + chunk);
         rep.out_data    = word;
         rep.last        = (off + chunk >= pay_len) || (nseg == MAX_RESULTS - 1);
         expected_replies.push_back(with_status(rep, save));
         off += chunk;
         nseg++;
      end
      if (nseg == 0) begin
         rep.frame_valid = 1'b0;
         rep.out_dlc     = '0;
         rep.out_data    = '0;
         rep.last        = 1'b1;
         expected_replies.push_back(with_status(rep, save));
      end
   endtask

   function automatic node_req_type frame_req(input logic [ID_W-1:0] id,
                                              input logic [DLC_W-1:0] dlc,
                                              input logic [DATA_W-1:0] data,
                                              input logic [TIME_W-1:0] now);
      node_req_type r;
      r.req_type   = REQ_FRAME;
      r.now_ms     = now;
      r.frame_id   = id;
      r.frame_dlc  = dlc;
      r.frame_data = data;
      return r;
   endfunction

   // a tick carries random frame fields, which the block must disregard
   function automatic node_req_type tick_req(input logic [TIME_W-1:0] now);
      node_req_type r;
      r.req_type   = REQ_TICK;
      r.now_ms     = now;
      r.frame_id   = ID_W'($urandom);
      r.frame_dlc  = DLC_W'($urandom);
      r.frame_data = {$urandom, $urandom};
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] discover_data(input logic [31:0] nonce);
      return {24'($urandom), nonce, OP_DISCOVER};
   endfunction

   function automatic logic [DATA_W-1:0] assign_data(input logic [7:0] seg,
                                                     input logic [7:0] len,
                                                     input logic [39:0] chunk);
      return {chunk, len, seg, OP_ASSIGN};
   endfunction

   // offer one request, idling first at random, and predict on acceptance
   task automatic send_request(input node_req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= r.req_type;
      req_bus.now_ms     <= r.now_ms;
      req_bus.frame_id   <= r.frame_id;
      req_bus.frame_dlc  <= r.frame_dlc;
      req_bus.frame_data <= r.frame_data;
      do @(posedge clock); while (!req_bus.ready);
      requests_sent++;
      predict_replies(r);
   endtask

   // hold the sender until every reply is in, then let the back end settle
   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      registers_written++;
      case (idx)
         CSR_DEVICE_UID:       cfg_uid      = value;
         CSR_BOARD_MODEL:      cfg_board    = value[15:0];
         CSR_FIRMWARE_VERSION: cfg_firmware = value[15:0];
         CSR_CAPABILITY_BITS:  cfg_caps     = value[15:0];
         CSR_INPUT_COUNT:      cfg_inputs   = value[7:0];
         CSR_OUTPUT_COUNT:     cfg_outputs  = value[7:0];
         CSR_STORED_NODE_ID: begin
            // a stored id other than none loads the node as assigned
            node_is_assigned = (value[7:0] != STORED_NONE);
            node_id          = node_is_assigned ? value[7:0] : NODE_UNASSIGNED;
         end
         default: ;
      endcase
   endtask

   task automatic load_registers(input logic [UID_W-1:0] uid, input logic [15:0] model,
                                 input logic [15:0] firmware, input logic [15:0] caps,
                                 input logic [7:0] n_in, input logic [7:0] n_out,
                                 input logic [7:0] stored);
      wait_until_drained();
      write_register(CSR_DEVICE_UID, uid);
      write_register(CSR_BOARD_MODEL, {48'h0, model});
      write_register(CSR_FIRMWARE_VERSION, {48'h0, firmware});
      write_register(CSR_CAPABILITY_BITS, {48'h0, caps});
      write_register(CSR_INPUT_COUNT, {56'h0, n_in});
      write_register(CSR_OUTPUT_COUNT, {56'h0, n_out});
      write_register(CSR_STORED_NODE_ID, {56'h0, stored});
      csr_bus.valid <= 1'b0;
   endtask

   // discover followed by a few ticks, sometimes close to the clock wrap
   task automatic send_discover_sequence();
      logic [31:0] t;
      int          ticks;
      int          k;
      if ($urandom_range(3) == 0) begin
         t = 32'hFFFF_FFF0 + $urandom_range(15);
      end else begin
         t = $urandom;
      end
      send_request(frame_req(ID_MASTER, DLC_W'($urandom_range(15, 5)),
                             discover_data($urandom), t));
      ticks = $urandom_range(3, 1);
      for (k = 0; k < ticks; k++) begin
         send_request(tick_req(t + $urandom_range(20)));
      end
   endtask

   // assign record cut into random chunks; optionally corrupt the uid or
   // start without segment zero
   task automatic send_assign_sequence(input logic corrupt, input logic skip_first);
      logic [7:0]  seq_bytes [0:DEF_ASSIGN_BYTES-1];
      logic [39:0] chunk;
      int          total;
      int          off;
      int          len;
      int          seg;
      int          i;
      for (i = 0; i < DEF_ASSIGN_BYTES; i++) begin
         seq_bytes[i] = (i < 8) ? cfg_uid[8*i +: 8] : 8'($urandom);
      end
      if (corrupt) begin
         seq_bytes[$urandom_range(7)] ^= 8'($urandom_range(255, 1));
      end
      total = $urandom_range(DEF_ASSIGN_BYTES, FINAL_MIN_BYTES);
      off   = 0;
      seg   = skip_first ? 1 : 0;
      while (off < total) begin
         len = $urandom_range(DEF_SEG_BYTES, 1);
         if (len > total - off) begin
            len = total - off;
         end
         chunk = {8'($urandom), $urandom};
         for (i = 0; i < len; i++) begin
            chunk[8*i +: 8] = seq_bytes[off + i];
         end
         send_request(frame_req(ID_MASTER, DLC_W'($urandom_range(15, 8)),
                                assign_data(8'(seg), 8'(len), chunk), $urandom));
         off += len;
         seg++;
      end
   endtask

   // fully random request with a bias towards the master id and known ops
   task automatic send_noise();
      node_req_type r;
      r.req_type   = 1'($urandom_range(1));
      r.now_ms     = $urandom;
      r.frame_id   = $urandom_range(1) ? ID_MASTER : ID_W'($urandom);
      r.frame_dlc  = DLC_W'($urandom_range(15));
      r.frame_data = {$urandom, $urandom};
      case ($urandom_range(4))
         0:       r.frame_data[7:0] = OP_DISCOVER;
         1:       r.frame_data[7:0] = OP_ASSIGN;
         2:       r.frame_data[7:0] = OP_IDENTIFY;
         3:       r.frame_data[7:0] = OP_ACK;
         default: ;
      endcase
      send_request(r);
   endtask

   task automatic test_discover_identify();
      load_registers(64'h0123_4567_89AB_CDEF, 16'hFFFF, 16'h0000, 16'hA5A5,
                     8'h00, 8'hFF, STORED_NONE);
      send_request(frame_req(ID_MASTER, 4'd5, discover_data(32'hDEAD_BEEF), 32'h0000_0100));
      // early tick, then a repeated discover that overwrites nonce and deadline
      send_request(tick_req(32'h0000_0100));
      send_request(frame_req(ID_MASTER, 4'd8, discover_data(32'h1234_5678), 32'h0000_0200));
      send_request(tick_req(32'h0000_020F));
      send_request(tick_req(32'h0000_0300));
      // large dlc near the clock wrap: the tick after the wrap must wait
      send_request(frame_req(ID_MASTER, 4'hF, discover_data(32'hFFFF_FFFF), 32'hFFFF_FFF8));
      send_request(tick_req(32'h0000_0000));
      send_request(tick_req(32'hFFFF_FFFF));
   endtask

   task automatic test_ignored_frames();
      send_request(frame_req(11'h000, 4'd8, discover_data($urandom), 32'h0));
      send_request(frame_req(11'h7FF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
      send_request(frame_req(ID_MASTER, 4'd3, discover_data($urandom), 32'h10));
      send_request(frame_req(ID_MASTER, 4'd4, discover_data($urandom), 32'h20));
      send_request(frame_req(ID_MASTER, 4'd8, {56'h0, OP_IDENTIFY}, 32'h30));
      send_request(frame_req(ID_MASTER, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 32'h40));
      send_request(frame_req(ID_MASTER, 4'd0, 64'h0, 32'h0));
   endtask

   task automatic test_assign_exchange();
      // matching record: node ff, input base ffff, output base 0
      send_request(frame_req(ID_MASTER, 4'd8, assign_data(8'd0, 8'd5, cfg_uid[39:0]), 32'h0));
      send_request(frame_req(ID_MASTER, 4'd8,
                             assign_data(8'd1, 8'd5, {8'hFF, 8'hFF, cfg_uid[63:40]}), 32'h1));
      send_request(frame_req(ID_MASTER, 4'd9,
                             assign_data(8'd2, 8'd3, {16'hBEEF, 16'h0000, 8'hFF}), 32'h2));
      // discover once assigned
      send_request(frame_req(ID_MASTER, 4'd8, discover_data($urandom), 32'h3));
      // long first chunk reads zeros past the frame, so the uid misses
      send_request(frame_req(ID_MASTER, 4'd8, assign_data(8'd0, 8'd8, cfg_uid[39:0]), 32'h4));
      send_request(frame_req(ID_MASTER, 4'd8, assign_data(8'd1, 8'd5, 40'h12_3456_789A), 32'h5));
      // overflowing chunk is dropped, then the buffer fills to the end
      send_request(frame_req(ID_MASTER, 4'd8, assign_data(8'd2, 8'd20, 40'hFF_FFFF_FFFF), 32'h6));
      send_request(frame_req(ID_MASTER, 4'd8, assign_data(8'd3, 8'd3, 40'h0), 32'h7));
      // short assign frame
      send_request(frame_req(ID_MASTER, 4'd7, assign_data(8'd1, 8'd0, 40'h0), 32'h8));
   endtask

   task automatic test_random_phase(input int send_pct, input int rsp_pct,
                                    input logic [UID_W-1:0] uid, input logic [15:0] model,
                                    input logic [15:0] firmware, input logic [15:0] caps,
                                    input logic [7:0] n_in, input logic [7:0] n_out,
                                    input logic [7:0] stored);
      int first;
      int pick;
      load_registers(uid, model, firmware, caps, n_in, n_out, stored);
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      first         = acted_requests;
      while (acted_requests - first < PHASE_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            send_discover_sequence();
         end else if (pick < 75) begin
            send_assign_sequence($urandom_range(3) == 0, $urandom_range(9) == 0);
         end else begin
            send_noise();
         end
      end
   endtask

   // hold the response side while identifies pile up behind it
   task automatic test_response_backpressure();
      logic [31:0] t;
      int          k;
      load_registers({$urandom, $urandom}, 16'($urandom), 16'($urandom), 16'($urandom),
                     8'($urandom), 8'($urandom), STORED_NONE);
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_request  = HOLD_CYCLES;
      for (k = 0; k < 4; k++) begin
         t = $urandom;
         send_request(frame_req(ID_MASTER, 4'd5, discover_data($urandom), t));
         send_request(tick_req(t + 32'd15));
      end
      wait_until_drained();
   endtask

   // response ready: random idling, or a counted hold-off when asked
   initial begin : rsp_ready_driver
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // compare each accepted reply with the oldest prediction
   always @(posedge clock) begin : check_replies
      node_reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         replies_checked++;
         if (rsp_bus.frame_valid && rsp_bus.out_data[7:0] == OP_IDENTIFY) begin
            identify_frames++;
         end
         if (rsp_bus.frame_valid && rsp_bus.out_data[7:0] == OP_ACK) begin
            ack_frames++;
         end
         if (expected_replies.size() == 0) begin
            report_mismatch("reply with none expected, out_data", rsp_bus.out_data, '0);
         end else begin
            want = expected_replies.pop_front();
            check_field("frame_valid", rsp_bus.frame_valid, want.frame_valid);
            check_field("out_dlc", rsp_bus.out_dlc, want.out_dlc);
            check_field("out_data", rsp_bus.out_data, want.out_data);
            check_field("last", rsp_bus.last, want.last);
            check_field("current_node_id", rsp_bus.current_node_id, want.node_id);
            check_field("node_assigned", rsp_bus.node_assigned, want.assigned);
            check_field("save_request", rsp_bus.save_request, want.save);
            check_field("input_base_index", rsp_bus.input_base_index, want.in_base);
            check_field("output_base_index", rsp_bus.output_base_index, want.out_base);
         end
      end
   end

   // end the run when no channel moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("node_id_provisioning_slave_top test failed");
      $finish;
   end

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.req_type   <= REQ_FRAME;
      req_bus.now_ms     <= '0;
      req_bus.frame_id   <= '0;
      req_bus.frame_dlc  <= '0;
      req_bus.frame_data <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= CSR_DEVICE_UID;
      csr_bus.data       <= '0;
      // node state after reset
      cfg_uid          = '0;
      cfg_board        = '0;
      cfg_firmware     = '0;
      cfg_caps         = '0;
      cfg_inputs       = '0;
      cfg_outputs      = '0;
      node_id          = NODE_UNASSIGNED;
      node_is_assigned = 1'b0;
      disc_nonce       = '0;
      ident_deadline   = '0;
      ident_pending    = 1'b0;
      assign_fill      = 0;
      base_in          = '0;
      base_out         = '0;
      foreach (assign_buf[i]) assign_buf[i] = 8'h00;
      hold_request      = 0;
      error_count       = 0;
      requests_sent     = 0;
      acted_requests    = 0;
      registers_written = 0;
      replies_checked   = 0;
      identify_frames   = 0;
      ack_frames        = 0;
      send_idle_pct     = 20;
      rsp_idle_pct      = 88;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_discover_identify();
      test_ignored_frames();
      test_assign_exchange();
      test_random_phase(20, 88, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        8'hFF, 8'hFF, STORED_NONE);
      test_random_phase(88, 20, {$urandom, $urandom}, 16'($urandom), 16'($urandom),
                        16'($urandom), 8'($urandom), 8'($urandom), STORED_NONE);
      test_random_phase(0, 0, 64'h0, 16'h0, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00);
      test_response_backpressure();
      wait_until_drained();

      $display("Covered %0d requests and %0d register writes; %0d replies checked",
               requests_sent, registers_written, replies_checked);
      $display("Segments seen: %0d identify, %0d acknowledge; %0d mismatches",
               identify_frames, ack_frames, error_count);
      if (error_count == 0) begin
         $display("node_id_provisioning_slave_top test passed");
      end else begin
         $display("node_id_provisioning_slave_top test failed");
      end
      $finish;
   end

endmodule
